// ===== hdl/echo_request_tracker_core_defines.svh =====
// assertion macros for the echo request tracker
`ifndef ECHO_REQUEST_TRACKER_CORE_DEFINES_SVH
`define ECHO_REQUEST_TRACKER_CORE_DEFINES_SVH

// plain property checked on every rising edge outside reset
`define ERT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define ERT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ERT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/ert_pkg.sv =====
// shared types and constants for the echo request tracker
`timescale 1ns / 1ps

package ert_pkg;

    // slot table size and derived widths
    localparam int TABLE_SLOTS = 128;
    localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W       = SLOT_W + 1;

    // field widths
    localparam int SLOT_IDX_W = 7;
    localparam int SEQ_W      = 16;
    localparam int TIME_W     = 32;
    localparam int RTT_W      = 23;
    localparam int LEN_W      = 14;

    // shortest icmp message in bytes
    localparam logic [LEN_W-1:0] MIN_ICMP_LEN = 14'd8;

    // divide by 1000: multiply by ceil(2^38 / 1000) then shift right by 38
    localparam int               RTT_MAGIC_W = 29;
    localparam logic [RTT_MAGIC_W-1:0] RTT_MAGIC = 29'd274877907;
    localparam int               RTT_SHIFT   = 38;
    localparam int               PROD_W      = TIME_W + RTT_MAGIC_W;

    // icmp echo reply type code
    localparam logic [7:0] ICMP_ECHO_REPLY = 8'd0;

    // event kinds
    localparam logic REQ_SEND  = 1'b0;
    localparam logic REQ_REPLY = 1'b1;

    // result status codes
    typedef enum logic [2:0] {
        ST_RECORDED = 3'd0,
        ST_FULL     = 3'd1,
        ST_MATCHED  = 3'd2,
        ST_SHORT    = 3'd3,
        ST_NOT_OURS = 3'd4,
        ST_UNKNOWN  = 3'd5
    } status_t;

endpackage

// ===== hdl/echo_request_tracker_core.sv =====
// echo request tracker: slot table in memory with round-trip timing
//
// channel    direction  handshake                      payload
// command    in         start, busy                    req_type .. reply_sequence
// result     out        result_valid (one-cycle pulse) status .. received_total
// config     in         cfg_valid, cfg_ready           cfg_data (own identifier)
//
// a send or a well-formed reply scans the slot memory one entry per cycle:
// a hit at slot k answers once slot k is compared, a full table or an
// unknown sequence once all TABLE_SLOTS (128) slots are compared; a reply match
// then passes S_MUL and S_OUT for the divide-by-1000 multiply. short or foreign
// replies answer from S_IDLE. the single read port of the slot memory sets the scan.
// reset clears the busy bits, counters and identifier at once; no sweep.
// busy blocks new commands while a scan or a match's multiply runs; results cannot be stalled.
`timescale 1ns / 1ps
`include "echo_request_tracker_core_defines.svh"

module echo_request_tracker_core
    import ert_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // command channel
    input  logic                  start,
    output logic                  busy,
    input  logic                  req_type,
    input  logic [TIME_W-1:0]     now_us,
    input  logic [3:0]            ip_header_words,
    input  logic [11:0]           packet_length,
    input  logic [7:0]            message_type,
    input  logic [SEQ_W-1:0]      message_ident,
    input  logic [SEQ_W-1:0]      reply_sequence,
    // result channel
    output logic                  result_valid,
    output logic [2:0]            status,
    output logic [SLOT_IDX_W-1:0] slot_index,
    output logic [SEQ_W-1:0]      sequence_out,
    output logic [RTT_W-1:0]      round_trip_ms,
    output logic [SEQ_W-1:0]      sent_total,
    output logic [SEQ_W-1:0]      received_total,
    // configuration channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [SEQ_W-1:0]      cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_MUL,
        S_OUT
    } state_t;

    localparam int MEM_W = SEQ_W + TIME_W;

    state_t                  state_reg;
    logic [SEQ_W-1:0]        own_id_reg;
    logic [SEQ_W-1:0]        send_cnt_reg;
    logic [SEQ_W-1:0]        reply_cnt_reg;
    logic [TABLE_SLOTS-1:0]  busy_vec_reg;

    // latched command
    logic                    req_reg;
    logic [TIME_W-1:0]       now_reg;
    logic [SEQ_W-1:0]        seq_reg;

    // scan pipeline
    logic [CNT_W-1:0]        issue_cnt_reg;
    logic                    cmp_valid_reg;
    logic [SLOT_W-1:0]       cmp_idx_reg;

    // round-trip datapath
    logic [TIME_W-1:0]       elapsed_reg;
    logic [PROD_W-1:0]       prod_reg;

    // result registers
    logic                    result_valid_reg;
    status_t                 status_reg;
    logic [SLOT_IDX_W-1:0]   slot_index_reg;
    logic [SEQ_W-1:0]        seq_out_reg;
    logic [RTT_W-1:0]        rtt_reg;

    // slot memory: sequence and send time
    logic [MEM_W-1:0]        slot_mem [TABLE_SLOTS];
    logic [MEM_W-1:0]        rd_data_reg;

    logic                    accept;
    logic                    too_short;
    logic                    not_ours;
    logic                    issue_more;
    logic                    mem_re;
    logic                    mem_we;
    logic [SLOT_W-1:0]       rd_addr;
    logic [SEQ_W-1:0]        rd_seq;
    logic [TIME_W-1:0]       rd_time;
    logic                    slot_free;
    logic                    hit;
    logic                    scan_done;

    // command decode
    assign accept    = start && (state_reg == S_IDLE);
    assign too_short = {2'b00, packet_length} <
                       ({8'b0, ip_header_words, 2'b00} + MIN_ICMP_LEN);
    assign not_ours  = (message_type != ICMP_ECHO_REPLY) || (message_ident != own_id_reg);

    // scan control
    assign issue_more = issue_cnt_reg < CNT_W'(TABLE_SLOTS);
    assign rd_addr    = issue_cnt_reg[SLOT_W-1:0];
    assign mem_re     = (state_reg == S_SCAN) && issue_more;
    assign rd_seq     = rd_data_reg[MEM_W-1:TIME_W];
    assign rd_time    = rd_data_reg[TIME_W-1:0];
    assign slot_free  = !busy_vec_reg[cmp_idx_reg];
    assign hit        = (state_reg == S_SCAN) && cmp_valid_reg &&
                        ((req_reg == REQ_REPLY) ? (!slot_free && (rd_seq == seq_reg))
                                                : slot_free);
    assign scan_done  = (state_reg == S_SCAN) && !cmp_valid_reg && !issue_more;
    assign mem_we     = hit && (req_reg == REQ_SEND);

    // slot memory, one read and one write port, read data registered
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[cmp_idx_reg] <= {send_cnt_reg, now_reg};
        end
        if (mem_re)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    // control state machine and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            own_id_reg       <= '0;
            send_cnt_reg     <= '0;
            reply_cnt_reg    <= '0;
            busy_vec_reg     <= '0;
            req_reg          <= REQ_SEND;
            now_reg          <= '0;
            seq_reg          <= '0;
            issue_cnt_reg    <= '0;
            cmp_valid_reg    <= 1'b0;
            cmp_idx_reg      <= '0;
            elapsed_reg      <= '0;
            prod_reg         <= '0;
            result_valid_reg <= 1'b0;
            status_reg       <= ST_RECORDED;
            slot_index_reg   <= '0;
            seq_out_reg      <= '0;
            rtt_reg          <= '0;
        end
        else
        begin
            result_valid_reg <= 1'b0;

            // configuration transfer
            if (cfg_valid)
            begin
                own_id_reg <= cfg_data;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        req_reg       <= req_type;
                        now_reg       <= now_us;
                        seq_reg       <= reply_sequence;
                        issue_cnt_reg <= '0;
                        cmp_valid_reg <= 1'b0;
                        if ((req_type == REQ_REPLY) && too_short)
                        begin
                            result_valid_reg <= 1'b1;
                            status_reg       <= ST_SHORT;
                            slot_index_reg   <= '0;
                            seq_out_reg      <= '0;
                            rtt_reg          <= '0;
                        end
                        else if ((req_type == REQ_REPLY) && not_ours)
                        begin
                            result_valid_reg <= 1'b1;
                            status_reg       <= ST_NOT_OURS;
                            slot_index_reg   <= '0;
                            seq_out_reg      <= '0;
                            rtt_reg          <= '0;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end

                S_SCAN:
                begin
                    // issue the next read and track which slot it was
                    cmp_valid_reg <= issue_more;
                    if (issue_more)
                    begin
                        cmp_idx_reg   <= rd_addr;
                        issue_cnt_reg <= issue_cnt_reg + 1'b1;
                    end

                    if (hit && (req_reg == REQ_SEND))
                    begin
                        busy_vec_reg[cmp_idx_reg] <= 1'b1;
                        send_cnt_reg     <= send_cnt_reg + 1'b1;
                        result_valid_reg <= 1'b1;
                        status_reg       <= ST_RECORDED;
                        slot_index_reg   <= SLOT_IDX_W'(cmp_idx_reg);
                        seq_out_reg      <= send_cnt_reg;
                        rtt_reg          <= '0;
                        state_reg        <= S_IDLE;
                    end
                    else if (hit)
                    begin
                        busy_vec_reg[cmp_idx_reg] <= 1'b0;
                        reply_cnt_reg  <= reply_cnt_reg + 1'b1;
                        elapsed_reg    <= now_reg - rd_time;
                        slot_index_reg <= SLOT_IDX_W'(cmp_idx_reg);
                        seq_out_reg    <= seq_reg;
                        state_reg      <= S_MUL;
                    end
                    else if (scan_done)
                    begin
                        result_valid_reg <= 1'b1;
                        status_reg       <= (req_reg == REQ_SEND) ? ST_FULL : ST_UNKNOWN;
                        slot_index_reg   <= '0;
                        seq_out_reg      <= '0;
                        rtt_reg          <= '0;
                        state_reg        <= S_IDLE;
                    end
                end

                S_MUL:
                begin
                    prod_reg  <= PROD_W'(elapsed_reg) * PROD_W'(RTT_MAGIC);
                    state_reg <= S_OUT;
                end

                S_OUT:
                begin
                    result_valid_reg <= 1'b1;
                    status_reg       <= ST_MATCHED;
                    rtt_reg          <= prod_reg[RTT_SHIFT +: RTT_W];
                    state_reg        <= S_IDLE;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // port drive
    assign busy           = (state_reg != S_IDLE);
    assign cfg_ready      = 1'b1;
    assign result_valid   = result_valid_reg;
    assign status         = status_reg;
    assign slot_index     = slot_index_reg;
    assign sequence_out   = seq_out_reg;
    assign round_trip_ms  = rtt_reg;
    assign sent_total     = send_cnt_reg;
    assign received_total = reply_cnt_reg;

    // checks
    `ERT_ASSERT(a_result_idle, !result_valid || !busy,
        "result strobe while a scan is still running")
    `ERT_ASSERT_NXT(a_accept_progress, start && !busy, busy || result_valid,
        "accepted command produced neither a scan nor a result")
    `ERT_ASSERT_IMP(a_sent_on_record, !$stable(sent_total),
        result_valid && (status == ST_RECORDED),
        "send counter moved without a recorded result")
    `ERT_ASSERT_IMP(a_recv_on_match, !$stable(received_total),
        busy && (state_reg == S_MUL),
        "reply counter moved outside a match")

endmodule

// ===== verif/echo_table_checker.sv =====
// echo request tracker checker: predicts each command outcome and compares results
`timescale 1ns / 1ps

module echo_table_checker
    import ert_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // command channel
    input  logic                  start,
    input  logic                  busy,
    input  logic                  req_type,
    input  logic [TIME_W-1:0]     now_us,
    input  logic [3:0]            ip_header_words,
    input  logic [11:0]           packet_length,
    input  logic [7:0]            message_type,
    input  logic [SEQ_W-1:0]      message_ident,
    input  logic [SEQ_W-1:0]      reply_sequence,
    // result channel
    input  logic                  result_valid,
    input  logic [2:0]            status,
    input  logic [SLOT_IDX_W-1:0] slot_index,
    input  logic [SEQ_W-1:0]      sequence_out,
    input  logic [RTT_W-1:0]      round_trip_ms,
    input  logic [SEQ_W-1:0]      sent_total,
    input  logic [SEQ_W-1:0]      received_total,
    // configuration channel
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [SEQ_W-1:0]      cfg_data,
    // totals for the top level
    output int                    fail_count,
    output int                    pending,
    output int                    result_count,
    output int                    matched_count,
    output int                    full_count
);

    localparam int US_PER_MS = 1000;

    typedef struct packed {
        status_t                 status;
        logic [SLOT_IDX_W-1:0]   slot;
        logic [SEQ_W-1:0]        seq;
        logic [RTT_W-1:0]        rtt;
        logic [SEQ_W-1:0]        sent;
        logic [SEQ_W-1:0]        rcvd;
    } echo_outcome_t;

    // predicted slot table, counters and identifier
    logic              slot_used  [TABLE_SLOTS];
    logic [SEQ_W-1:0]  slot_seq   [TABLE_SLOTS];
    logic [TIME_W-1:0] slot_stamp [TABLE_SLOTS];
    logic [SEQ_W-1:0]  sends_recorded;
    logic [SEQ_W-1:0]  replies_matched;
    logic [SEQ_W-1:0]  ident_reg;

    // outcomes still owed by the block, oldest first
    echo_outcome_t outcome_q[$];

    // outcome of one command, applied to the predicted table
    function automatic echo_outcome_t predict_outcome(
        input logic              kind,
        input logic [TIME_W-1:0] stamp,
        input logic [3:0]        hdr_words,
        input logic [11:0]       pkt_len,
        input logic [7:0]        msg_type,
        input logic [SEQ_W-1:0]  ident,
        input logic [SEQ_W-1:0]  seq
    );
        echo_outcome_t     res;
        int                icmp_len;
        int                hit;
        logic [TIME_W-1:0] elapsed;
        res = '0;
        hit = -1;
        if (kind == REQ_SEND) begin
            // lowest free slot
            for (int i = TABLE_SLOTS - 1; i >= 0; i--)
                if (!slot_used[i])
                    hit = i;
            if (hit < 0)
                res.status = ST_FULL;
            else begin
                slot_used[hit]  = 1'b1;
                slot_seq[hit]   = sends_recorded;
                slot_stamp[hit] = stamp;
                res.status = ST_RECORDED;
                res.slot   = hit[SLOT_IDX_W-1:0];
                res.seq    = sends_recorded;
                sends_recorded = sends_recorded + 1'b1;
            end
        end else begin
            icmp_len = int'(pkt_len) - 4 * int'(hdr_words);
            if (icmp_len < int'(MIN_ICMP_LEN))
                res.status = ST_SHORT;
            else if (msg_type != ICMP_ECHO_REPLY || ident != ident_reg)
                res.status = ST_NOT_OURS;
            else begin
                // lowest busy slot holding this sequence
                for (int i = TABLE_SLOTS - 1; i >= 0; i--)
                    if (slot_used[i] && slot_seq[i] == seq)
                        hit = i;
                if (hit < 0)
                    res.status = ST_UNKNOWN;
                else begin
                    elapsed = stamp - slot_stamp[hit];
                    slot_used[hit] = 1'b0;
                    replies_matched = replies_matched + 1'b1;
                    res.status = ST_MATCHED;
                    res.slot   = hit[SLOT_IDX_W-1:0];
                    res.seq    = seq;
                    res.rtt    = RTT_W'(elapsed / US_PER_MS);
                end
            end
        end
        res.sent = sends_recorded;
        res.rcvd = replies_matched;
        return res;
    endfunction

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            fail_count++;
        end
    endtask

    // result check, identifier update and prediction per clock
    always @(posedge clk or negedge rst_n)
    begin
        echo_outcome_t want;
        if (!rst_n) begin
            for (int i = 0; i < TABLE_SLOTS; i++)
                slot_used[i] = 1'b0;
            sends_recorded  = '0;
            replies_matched = '0;
            ident_reg       = '0;
            outcome_q.delete();
            fail_count      = 0;
            result_count    = 0;
            matched_count   = 0;
            full_count      = 0;
            pending        <= 0;
        end else begin
            // result transfer
            if (result_valid) begin
                result_count++;
                if (status == ST_MATCHED)
                    matched_count++;
                if (status == ST_FULL)
                    full_count++;
                if (outcome_q.size() == 0) begin
                    $display("%0t: result with nothing expected, status %0d", $time, status);
                    fail_count++;
                end else begin
                    want = outcome_q.pop_front();
                    compare_field("status", want.status, status);
                    compare_field("slot_index", want.slot, slot_index);
                    compare_field("sequence_out", want.seq, sequence_out);
                    compare_field("round_trip_ms", want.rtt, round_trip_ms);
                    compare_field("sent_total", want.sent, sent_total);
                    compare_field("received_total", want.rcvd, received_total);
                end
            end
            // command transfer, seeing the identifier from before this edge
            if (start && !busy)
                outcome_q.push_back(predict_outcome(req_type, now_us, ip_header_words,
                                                    packet_length, message_type,
                                                    message_ident, reply_sequence));
            // identifier write
            if (cfg_valid && cfg_ready)
                ident_reg = cfg_data;
            pending <= outcome_q.size();
        end
    end

endmodule

// ===== verif/tb_top.sv =====
// testbench top for the echo request tracker: stimulus, clock, reset and verdict
`timescale 1ns / 1ps

module tb_top;
    import ert_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  req_type = 1'b0;
    logic [TIME_W-1:0]     now_us = '0;
    logic [3:0]            ip_header_words = '0;
    logic [11:0]           packet_length = '0;
    logic [7:0]            message_type = '0;
    logic [SEQ_W-1:0]      message_ident = '0;
    logic [SEQ_W-1:0]      reply_sequence = '0;
    logic                  result_valid;
    logic [2:0]            status;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [SEQ_W-1:0]      sequence_out;
    logic [RTT_W-1:0]      round_trip_ms;
    logic [SEQ_W-1:0]      sent_total;
    logic [SEQ_W-1:0]      received_total;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [SEQ_W-1:0]      cfg_data = '0;

    int fail_count;
    int pending;
    int result_count;
    int matched_count;
    int full_count;

    // stimulus bookkeeping
    int                commands_issued = 0;
    int                ident_writes = 0;
    bit                no_idle = 1'b0;
    logic [SEQ_W-1:0]  own_id = '0;
    logic [SEQ_W-1:0]  last_sent_total = '0;
    logic [TIME_W-1:0] time_base;

    echo_request_tracker_core uut (
        .clk(clk), .rst_n(rst_n),
        .start(start), .busy(busy),
        .req_type(req_type), .now_us(now_us), .ip_header_words(ip_header_words),
        .packet_length(packet_length), .message_type(message_type),
        .message_ident(message_ident), .reply_sequence(reply_sequence),
        .result_valid(result_valid), .status(status), .slot_index(slot_index),
        .sequence_out(sequence_out), .round_trip_ms(round_trip_ms),
        .sent_total(sent_total), .received_total(received_total),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    echo_table_checker table_chk (
        .clk(clk), .rst_n(rst_n),
        .start(start), .busy(busy),
        .req_type(req_type), .now_us(now_us), .ip_header_words(ip_header_words),
        .packet_length(packet_length), .message_type(message_type),
        .message_ident(message_ident), .reply_sequence(reply_sequence),
        .result_valid(result_valid), .status(status), .slot_index(slot_index),
        .sequence_out(sequence_out), .round_trip_ms(round_trip_ms),
        .sent_total(sent_total), .received_total(received_total),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending), .result_count(result_count),
        .matched_count(matched_count), .full_count(full_count)
    );

    // clock
    always #10 clk = ~clk;

    // latest send count, used to aim replies at outstanding sequences
    always @(posedge clk)
    begin
        if (result_valid)
            last_sent_total <= sent_total;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(30, 150);
    endfunction

    // free-running microsecond clock with occasional jumps
    function automatic logic [TIME_W-1:0] next_now();
        if ($urandom_range(0, 39) == 0)
            time_base = $urandom;
        else
            time_base = time_base + $urandom_range(0, 150000);
        return time_base;
    endfunction

    // one command transfer, after an optional gap
    task automatic issue_command(input logic kind, input logic [TIME_W-1:0] stamp,
                                 input logic [3:0] hdr, input logic [11:0] len,
                                 input logic [7:0] mtype, input logic [SEQ_W-1:0] ident,
                                 input logic [SEQ_W-1:0] seq);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start           <= 1'b1;
        req_type        <= kind;
        now_us          <= stamp;
        ip_header_words <= hdr;
        packet_length   <= len;
        message_type    <= mtype;
        message_ident   <= ident;
        reply_sequence  <= seq;
        do @(posedge clk); while (busy);
        commands_issued++;
    endtask

    // send event; the reply-only fields carry random values
    task automatic send_at(input logic [TIME_W-1:0] stamp);
        issue_command(REQ_SEND, stamp, 4'($urandom), 12'($urandom), 8'($urandom),
                      16'($urandom), 16'($urandom));
    endtask

    // mostly well-formed replies aimed at recent sequences, the rest noise
    task automatic random_reply();
        logic [3:0]       hdr;
        logic [11:0]      len;
        logic [SEQ_W-1:0] seq;
        hdr = 4'($urandom_range(5, 15));
        if ($urandom_range(0, 99) < 80) begin
            len = 12'($urandom_range(int'(hdr) * 4 + 8, 4095));
            if ($urandom_range(0, 9) == 0)
                seq = 16'($urandom);
            else
                seq = last_sent_total - 16'($urandom_range(1, 140));
            issue_command(REQ_REPLY, next_now(), hdr, len, ICMP_ECHO_REPLY, own_id, seq);
        end else begin
            issue_command(REQ_REPLY, next_now(), 4'($urandom), 12'($urandom),
                          $urandom_range(0, 1) ? ICMP_ECHO_REPLY : 8'($urandom),
                          $urandom_range(0, 1) ? own_id : 16'($urandom), 16'($urandom));
        end
    endtask

    // hold off until every owed result has arrived
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (pending != 0 || busy);
    endtask

    // identifier write while the block is idle
    task automatic write_identifier(input logic [SEQ_W-1:0] value);
        drain();
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        own_id = value;
        ident_writes++;
    endtask

    // run limit
    initial
    begin
        #50_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        logic [SEQ_W-1:0] ident_plan [6];
        int               send_pct;
        time_base = $urandom;
        ident_plan[0] = 16'hFFFF;
        ident_plan[1] = 16'($urandom);
        ident_plan[2] = 16'h0000;
        ident_plan[3] = 16'($urandom);
        ident_plan[4] = 16'h8001;
        ident_plan[5] = 16'($urandom);

        // reset
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: identifier still at its reset value of zero
        issue_command(REQ_REPLY, 32'd500, 4'd5, 12'd64, ICMP_ECHO_REPLY, 16'h0000, 16'd0);
        send_at(32'h0000_0000);
        send_at(32'd1000);
        send_at(32'hFFFF_F000);
        // longest round trip, then the same sequence once freed
        issue_command(REQ_REPLY, 32'hFFFF_FFFF, 4'd5, 12'd84, ICMP_ECHO_REPLY, 16'h0, 16'd0);
        issue_command(REQ_REPLY, 32'hFFFF_FFFF, 4'd5, 12'd84, ICMP_ECHO_REPLY, 16'h0, 16'd0);
        // freed slot zero is taken again
        send_at(32'd5);
        // time wraps between send and reply
        issue_command(REQ_REPLY, 32'h0001_0000, 4'd5, 12'd84, ICMP_ECHO_REPLY, 16'h0, 16'd2);
        // foreign identifier and wrong types
        issue_command(REQ_REPLY, 32'd2000, 4'd5, 12'd84, ICMP_ECHO_REPLY, 16'h0001, 16'd1);
        issue_command(REQ_REPLY, 32'd2000, 4'd5, 12'd84, 8'd8, 16'h0, 16'd1);
        issue_command(REQ_REPLY, 32'd2000, 4'd5, 12'd84, 8'hFF, 16'h0, 16'd1);
        // header longer than the packet, and one byte under the minimum
        issue_command(REQ_REPLY, 32'd2000, 4'd15, 12'd20, ICMP_ECHO_REPLY, 16'h0, 16'd1);
        issue_command(REQ_REPLY, 32'd2000, 4'd5, 12'd27, ICMP_ECHO_REPLY, 16'h0, 16'd1);
        // too short wins over a wrong type and identifier
        issue_command(REQ_REPLY, 32'd2000, 4'd2, 12'd15, 8'd8, 16'h1234, 16'd1);
        issue_command(REQ_REPLY, 32'd2000, 4'd0, 12'd0, ICMP_ECHO_REPLY, 16'h0, 16'd1);
        // exactly the minimum length, under one millisecond
        issue_command(REQ_REPLY, 32'd1999, 4'd5, 12'd28, ICMP_ECHO_REPLY, 16'h0, 16'd1);
        issue_command(REQ_REPLY, 32'd3000, 4'd0, 12'hFFF, 8'hFF, 16'hFFFF, 16'hFFFF);
        issue_command(REQ_REPLY, 32'd3000, 4'd15, 12'hFFF, ICMP_ECHO_REPLY, 16'h0, 16'hFFFF);
        issue_command(REQ_REPLY, 32'd1005, 4'd5, 12'd84, ICMP_ECHO_REPLY, 16'h0, 16'd3);

        // fill the table past its end
        for (int n = 0; n < 140; n++) begin
            no_idle = (n < 70);
            send_at(next_now());
        end
        no_idle = 1'b0;

        // random phases, alternating between filling and draining the table
        for (int phase = 0; phase < 6; phase++) begin
            write_identifier(ident_plan[phase]);
            send_pct = (phase % 2 == 0) ? 70 : 35;
            for (int n = 0; n < 300; n++) begin
                no_idle = (n % 100) < 25;
                if (n == 150)
                    drain();
                if ($urandom_range(0, 99) < send_pct)
                    send_at(next_now());
                else
                    random_reply();
            end
        end

        // wind down
        drain();
        repeat (150) @(posedge clk);
        $display("covered %0d commands under %0d identifier writes, %0d results",
                 commands_issued, ident_writes, result_count);
        $display("of which %0d matched replies and %0d sends against a full table",
                 matched_count, full_count);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
